FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, skipped while reset is asserted
`define TVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked property, also during reset
`define TVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/tve_pkg.sv
`default_nettype none
package tve_pkg;

  localparam int NUM_DEVICES = 2;
  localparam int DEV_W       = 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAU    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_MAX = 2'd2;

  localparam logic [23:0] TAU_RESET    = 24'd50000;
  localparam logic [31:0] DT_MIN_RESET = 32'd2000000;
  localparam logic [31:0] DT_MAX_RESET = 32'd50000000;

  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;

  // Shared divider geometry
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_DIV_R,
    OP_ALPHA1,
    OP_ALPHA2,
    OP_ALPHA3,
    OP_DIFF,
    OP_MUL,
    OP_DIV_V,
    OP_LV,
    OP_PROD,
    OP_UPD,
    OP_STORE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic gate;
    logic div_done;
    logic div_busy;
  } stat_t;

  // exp(-n), Q1.16
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] v;
    unique case (n)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd24109;
      4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;
      4'd4:  v = 17'd1200;
      4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;
      4'd7:  v = 17'd60;
      4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      4'd12: v = 17'd0;
      4'd13: v = 17'd0;
      4'd14: v = 17'd0;
      4'd15: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-k/16), Q1.16
  function automatic logic [16:0] exp_frac(input logic [3:0] k);
    logic [16:0] v;
    unique case (k)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      4'd15: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tve_div.sv
`default_nettype none
module tve_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [tve_pkg::DIV_NUM_W-1:0]   num_i,
  input  wire logic [tve_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic [tve_pkg::DIV_NUM_W-1:0]        quo_o
);

  logic [tve_pkg::DIV_NUM_W-1:0] quo_q, quo_d;
  logic [tve_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [tve_pkg::DIV_DEN_W-1:0] den_q;
  logic [tve_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [tve_pkg::DIV_DEN_W:0]   trial;
  logic                          ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[tve_pkg::DIV_NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    if (ge) begin
      rem_d = tve_pkg::DIV_DEN_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[tve_pkg::DIV_DEN_W-1:0];
    end
    quo_d = {quo_q[tve_pkg::DIV_NUM_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= tve_pkg::DIV_CNT_W'(tve_pkg::DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tve_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

FILE: hdl/tve_dp.sv
`default_nettype none
module tve_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tve_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tve_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [tve_pkg::DEV_W-1:0]         device_i,
  input  wire logic signed [31:0]                pos_x_i,
  input  wire logic signed [31:0]                pos_y_i,
  input  wire logic signed [31:0]                pos_z_i,
  input  wire logic [63:0]                       stamp_ns_i,
  input  wire tve_pkg::cmd_t                     cmd_i,
  output tve_pkg::stat_t                         stat_o,
  output logic signed [31:0]                     vel_x_o,
  output logic signed [31:0]                     vel_y_o,
  output logic signed [31:0]                     vel_z_o,
  output logic                                   updated_o
);

  // Configuration
  logic [23:0] tau_q;
  logic [31:0] dt_min_q, dt_max_q;

  // Per-device state
  logic                     seen_q       [tve_pkg::NUM_DEVICES];
  logic [63:0]              last_stamp_q [tve_pkg::NUM_DEVICES];
  logic signed [31:0]       last_pos_q   [tve_pkg::NUM_DEVICES][3];
  logic signed [31:0]       vel_q        [tve_pkg::NUM_DEVICES][3];

  // Current sample
  logic [tve_pkg::DEV_W-1:0] dev_q;
  logic signed [31:0]        pos_q [3];
  logic [63:0]               stamp_q;

  // Working registers
  logic [31:0]        dt_q;
  logic               gate_q;
  logic [33:0]        e1m_q;
  logic [16:0]        p_q;
  logic               ezero_q;
  logic [33:0]        eprod_q;
  logic [15:0]        alpha_q;
  logic               neg_q;
  logic [32:0]        mag_q;
  logic [62:0]        num_q;
  logic signed [31:0] lv_q;
  logic signed [49:0] prod_q;

  // Output payload
  logic signed [31:0] out_vel_q [3];
  logic               out_upd_q;

  logic                               dev_ok;
  logic [1:0]                         ax;
  logic [63:0]                        dt_full;
  logic                               div_start, div_busy, div_done;
  logic [tve_pkg::DIV_NUM_W-1:0]      div_num, div_quo;
  logic [tve_pkg::DIV_DEN_W-1:0]      div_den;
  logic [23:0]                        tau_eff;
  logic [11:0]                        dd;
  logic [23:0]                        dd_sq;
  logic [16:0]                        e1, e_val;
  logic [34:0]                        e1_sum, e_sum;
  logic signed [32:0]                 diff;
  logic signed [32:0]                 delta;
  logic signed [49:0]                 prod_rnd;
  logic signed [33:0]                 prod_sh;
  logic signed [34:0]                 vel_sum;
  logic signed [31:0]                 vel_sat;
  logic signed [31:0]                 v_cur;
  logic signed [31:0]                 lv_val;

  assign dev_ok  = int'(dev_q) < tve_pkg::NUM_DEVICES;
  assign ax      = cmd_i.axis;
  assign dt_full = stamp_q - last_stamp_q[dev_q];
  assign tau_eff = (tau_q == 24'd0) ? 24'd1 : tau_q;
  assign v_cur   = vel_q[dev_q][ax];

  // Divider operand selection: dt/tau ratio or finite difference
  always_comb begin
    div_start = (cmd_i.op == tve_pkg::OP_DIV_R) || (cmd_i.op == tve_pkg::OP_DIV_V);
    if (cmd_i.op == tve_pkg::OP_DIV_R) begin
      div_num = {20'd0, dt_q, 12'd0};
      div_den = 34'(tau_eff) * 34'(tve_pkg::NS_PER_US);
    end else begin
      div_num = {1'b0, num_q};
      div_den = {2'd0, dt_q};
    end
  end

  tve_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Alpha arithmetic pieces
  always_comb begin
    dd     = {div_quo[7:0], 4'd0};
    dd_sq  = 24'(dd) * 24'(dd);
    e1_sum = {1'b0, e1m_q} + 35'd32768;
    e1     = e1_sum[32:16];
    e_sum  = {1'b0, eprod_q} + 35'd32768;
    e_val  = ezero_q ? 17'd0 : e_sum[32:16];
  end

  // Finite difference, velocity clip and blend
  always_comb begin
    diff = 33'(pos_q[ax]) - 33'(last_pos_q[dev_q][ax]);
    if (neg_q) begin
      lv_val = (|div_quo[63:31]) ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
    end else begin
      lv_val = (|div_quo[63:31]) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
    end
    delta    = 33'(lv_q) - 33'(v_cur);
    prod_rnd = prod_q + 50'sd32768;
    prod_sh  = 34'(prod_rnd >>> 16);
    vel_sum  = 35'(v_cur) + 35'(prod_sh);
    if (vel_sum > 35'sd2147483647) begin
      vel_sat = 32'sh7FFF_FFFF;
    end else if (vel_sum < -35'sd2147483648) begin
      vel_sat = 32'sh8000_0000;
    end else begin
      vel_sat = vel_sum[31:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q    <= tve_pkg::TAU_RESET;
      dt_min_q <= tve_pkg::DT_MIN_RESET;
      dt_max_q <= tve_pkg::DT_MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tve_pkg::CFG_TAU:    tau_q    <= cfg_data_i[23:0];
        tve_pkg::CFG_DT_MIN: dt_min_q <= cfg_data_i;
        tve_pkg::CFG_DT_MAX: dt_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Seen flags and smoothed velocities, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < tve_pkg::NUM_DEVICES; d++) begin
        seen_q[d] <= 1'b0;
        for (int a = 0; a < 3; a++) begin
          vel_q[d][a] <= '0;
        end
      end
    end else begin
      if (cmd_i.op == tve_pkg::OP_UPD) begin
        vel_q[dev_q][ax] <= vel_sat;
      end
      if (cmd_i.op == tve_pkg::OP_STORE && dev_ok) begin
        seen_q[dev_q] <= 1'b1;
      end
    end
  end

  // Last sample per device, valid once seen
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tve_pkg::OP_STORE && dev_ok) begin
      last_stamp_q[dev_q] <= stamp_q;
      for (int a = 0; a < 3; a++) begin
        last_pos_q[dev_q][a] <= pos_q[a];
      end
    end
  end

  // Gate flag and the updated flag of the stored result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q    <= 1'b0;
      out_upd_q <= 1'b0;
    end else begin
      if (cmd_i.op == tve_pkg::OP_CHECK) begin
        gate_q <= dev_ok && seen_q[dev_q] && (dt_full > {32'd0, dt_min_q})
                  && (dt_full < {32'd0, dt_max_q});
      end
      if (cmd_i.op == tve_pkg::OP_STORE) begin
        out_upd_q <= gate_q;
      end
    end
  end

  // Working datapath registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      tve_pkg::OP_LOAD: begin
        dev_q    <= device_i;
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        stamp_q  <= stamp_ns_i;
      end
      tve_pkg::OP_CHECK: begin
        dt_q <= dt_full[31:0];
      end
      tve_pkg::OP_ALPHA1: begin
        ezero_q <= |div_quo[63:16];
        e1m_q   <= 34'(tve_pkg::exp_int(div_quo[15:12]))
                   * 34'(tve_pkg::exp_frac(div_quo[11:8]));
        p_q     <= 17'd65536 - 17'(dd) + 17'(dd_sq[23:17]);
      end
      tve_pkg::OP_ALPHA2: begin
        eprod_q <= 34'(e1) * 34'(p_q);
      end
      tve_pkg::OP_ALPHA3: begin
        alpha_q <= (e_val == 17'd0) ? 16'hFFFF : 16'(17'd65536 - e_val);
      end
      tve_pkg::OP_DIFF: begin
        neg_q <= diff[32];
        mag_q <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      tve_pkg::OP_MUL: begin
        num_q <= 63'(mag_q) * 63'(tve_pkg::NS_PER_S);
      end
      tve_pkg::OP_LV: begin
        lv_q <= lv_val;
      end
      tve_pkg::OP_PROD: begin
        prod_q <= 50'(delta) * 50'($signed({1'b0, alpha_q}));
      end
      tve_pkg::OP_STORE: begin
        for (int a = 0; a < 3; a++) begin
          out_vel_q[a] <= dev_ok ? vel_q[dev_q][a] : 32'sd0;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.gate     = gate_q;
  assign stat_o.div_done = div_done;
  assign stat_o.div_busy = div_busy;
  assign vel_x_o   = out_vel_q[0];
  assign vel_y_o   = out_vel_q[1];
  assign vel_z_o   = out_vel_q[2];
  assign updated_o = out_upd_q;

endmodule
`default_nettype wire

FILE: hdl/tve_ctrl.sv
`default_nettype none
module tve_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire tve_pkg::stat_t stat_i,
  output tve_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_DIVR   = 4'd3;
  localparam logic [3:0] S_WAITR  = 4'd4;
  localparam logic [3:0] S_A1     = 4'd5;
  localparam logic [3:0] S_A2     = 4'd6;
  localparam logic [3:0] S_A3     = 4'd7;
  localparam logic [3:0] S_DIFF   = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_DIVV   = 4'd10;
  localparam logic [3:0] S_WAITV  = 4'd11;
  localparam logic [3:0] S_LV     = 4'd12;
  localparam logic [3:0] S_PROD   = 4'd13;
  localparam logic [3:0] S_UPD    = 4'd14;
  localparam logic [3:0] S_STORE  = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = tve_pkg::OP_NONE;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tve_pkg::OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.op = tve_pkg::OP_CHECK;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = stat_i.gate ? S_DIVR : S_STORE;
      end
      S_DIVR: begin
        cmd_o.op = tve_pkg::OP_DIV_R;
        state_d  = S_WAITR;
      end
      S_WAITR: begin
        if (stat_i.div_done) begin
          state_d = S_A1;
        end
      end
      S_A1: begin
        cmd_o.op = tve_pkg::OP_ALPHA1;
        state_d  = S_A2;
      end
      S_A2: begin
        cmd_o.op = tve_pkg::OP_ALPHA2;
        state_d  = S_A3;
      end
      S_A3: begin
        cmd_o.op = tve_pkg::OP_ALPHA3;
        axis_d   = 2'd0;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = tve_pkg::OP_DIFF;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = tve_pkg::OP_MUL;
        state_d  = S_DIVV;
      end
      S_DIVV: begin
        cmd_o.op = tve_pkg::OP_DIV_V;
        state_d  = S_WAITV;
      end
      S_WAITV: begin
        if (stat_i.div_done) begin
          state_d = S_LV;
        end
      end
      S_LV: begin
        cmd_o.op = tve_pkg::OP_LV;
        state_d  = S_PROD;
      end
      S_PROD: begin
        cmd_o.op = tve_pkg::OP_PROD;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = tve_pkg::OP_UPD;
        if (axis_q == 2'd2) begin
          state_d = S_STORE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_DIFF;
        end
      end
      S_STORE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd_o.op    = tve_pkg::OP_STORE;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: hdl/tracker_velocity_estimator.sv
// Flow: a sample that does not update passes load, check and store; one that
// does runs the shared divider for dt/tau and the alpha steps, then for each
// axis the finite difference, a divider run for it, the clip and the blend.
// A new sample is taken only after the last is stored, but it is taken while the
// last result waits, the store step stalls until the output register is free.
// Reset: asynchronous, active low; clears seen flags and velocities, loads defaults.
`default_nettype none
`include "assert_macros.svh"
module tracker_velocity_estimator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tve_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tve_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [tve_pkg::DEV_W-1:0]       device_i,
  input  wire logic signed [31:0]              pos_x_i,
  input  wire logic signed [31:0]              pos_y_i,
  input  wire logic signed [31:0]              pos_z_i,
  input  wire logic [63:0]                     stamp_ns_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [31:0]                   vel_x_o,
  output logic signed [31:0]                   vel_y_o,
  output logic signed [31:0]                   vel_z_o,
  output logic                                 updated_o
);

  tve_pkg::cmd_t  cmd;
  tve_pkg::stat_t stat;

  tve_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tve_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .device_i   (device_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .stamp_ns_i (stamp_ns_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .vel_x_o    (vel_x_o),
    .vel_y_o    (vel_y_o),
    .vel_z_o    (vel_z_o),
    .updated_o  (updated_o)
  );

  // Sequencer leaves idle after taking a sample
  `TVE_ASSERT(a_busy_after_take, (in_valid_i && in_ready_o) |=> !in_ready_o, "idle after transfer")
  // Divider only runs while a sample is in work
  `TVE_ASSERT(a_div_idle, in_ready_o |-> (!stat.div_busy && !stat.div_done), "divider active while idle")
  // A result is only raised on leaving the store step
  `TVE_ASSERT(a_out_rise, $rose(out_valid_o) |-> in_ready_o, "result raised outside store")

endmodule
`default_nettype wire

FILE: sim/tracker_velocity_estimator_check.sv
`timescale 1ns / 100ps
module tracker_velocity_estimator_check (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tve_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tve_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic [tve_pkg::DEV_W-1:0]       device_i,
  input  wire logic signed [31:0]              pos_x_i,
  input  wire logic signed [31:0]              pos_y_i,
  input  wire logic signed [31:0]              pos_z_i,
  input  wire logic [63:0]                     stamp_ns_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic signed [31:0]              vel_x_i,
  input  wire logic signed [31:0]              vel_y_i,
  input  wire logic signed [31:0]              vel_z_i,
  input  wire logic                            updated_i,
  output int                                   err_count_o,
  output int                                   pending_o,
  output int                                   updates_o
);

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               upd;
  } velocity_t;

  // exp(-n) and exp(-k/16), Q1.16
  localparam logic [16:0] EXP_WHOLE [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
    17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0};
  localparam logic [16:0] EXP_SIXTEENTH [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
    17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
    17'd27319, 17'd25664};

  logic [23:0]        tau_q;
  logic [31:0]        gate_lo_q;
  logic [31:0]        gate_hi_q;
  logic               seen_q   [tve_pkg::NUM_DEVICES];
  logic [63:0]        stamp_q  [tve_pkg::NUM_DEVICES];
  logic signed [31:0] pos_q    [tve_pkg::NUM_DEVICES][3];
  logic signed [31:0] vel_q    [tve_pkg::NUM_DEVICES][3];
  velocity_t          expected_vel_q[$];
  int                 mismatches;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(64'sh80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // alpha = 1 - exp(-dt/tau), Q0.16
  function automatic logic [15:0] smoothing_gain(input logic [63:0] dt);
    logic [63:0] tau, r, d, p, e1, e;
    tau = (tau_q == 0) ? 64'd1 : 64'(tau_q);
    r = (dt * 64'd4096) / (tau * 64'd1000);
    if (r >= 64'd65536) begin
      e = 0;
    end else begin
      d  = (r & 64'd255) * 64'd16;
      p  = 64'd65536 - d + ((d * d) >> 17);
      e1 = (64'(EXP_WHOLE[r[15:12]]) * 64'(EXP_SIXTEENTH[r[11:8]]) + 64'd32768) >> 16;
      e  = (e1 * p + 64'd32768) >> 16;
    end
    if (e > 64'd65536) e = 64'd65536;
    e = 64'd65536 - e;
    return (e > 64'd65535) ? 16'hffff : e[15:0];
  endfunction

  // finite-difference rate, truncated toward zero
  function automatic logic signed [31:0] axis_rate(input logic signed [31:0] now,
                                                   input logic signed [31:0] prev,
                                                   input logic [63:0] dt);
    longint      diff;
    logic [63:0] mag, q;
    diff = longint'(now) - longint'(prev);
    mag  = (diff < 0) ? -diff : diff;
    q    = (mag * 64'd1000000000) / dt;
    if (q > 64'h80000000) q = 64'h80000000;
    return clamp32((diff < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic velocity_t track_sample(input logic dev,
                                             input logic signed [31:0] px,
                                             input logic signed [31:0] py,
                                             input logic signed [31:0] pz,
                                             input logic [63:0] stamp);
    logic signed [31:0] pos [3];
    logic [63:0]        dt;
    logic [15:0]        gain;
    longint             v, prod;
    velocity_t          res;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    res.upd = 1'b0;
    if (seen_q[dev]) begin
      dt = stamp - stamp_q[dev];
      if (dt > 64'(gate_lo_q) && dt < 64'(gate_hi_q)) begin
        gain = smoothing_gain(dt);
        for (int a = 0; a < 3; a++) begin
          v    = longint'(vel_q[dev][a]);
          prod = (longint'(axis_rate(pos[a], pos_q[dev][a], dt)) - v) * longint'({48'd0, gain});
          vel_q[dev][a] = clamp32(v + ((prod + 64'sd32768) >>> 16));
        end
        res.upd = 1'b1;
      end
    end
    for (int a = 0; a < 3; a++) pos_q[dev][a] = pos[a];
    stamp_q[dev] = stamp;
    seen_q[dev]  = 1'b1;
    res.vx = vel_q[dev][0];
    res.vy = vel_q[dev][1];
    res.vz = vel_q[dev][2];
    return res;
  endfunction

  assign pending_o = expected_vel_q.size();

  // track registers, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    velocity_t got, want;
    if (!rst_ni) begin
      tau_q     <= tve_pkg::TAU_RESET;
      gate_lo_q <= tve_pkg::DT_MIN_RESET;
      gate_hi_q <= tve_pkg::DT_MAX_RESET;
      for (int d = 0; d < tve_pkg::NUM_DEVICES; d++) begin
        seen_q[d]  = 1'b0;
        stamp_q[d] = '0;
        for (int a = 0; a < 3; a++) begin
          pos_q[d][a] = '0;
          vel_q[d][a] = '0;
        end
      end
      expected_vel_q.delete();
      mismatches  = 0;
      err_count_o = 0;
      updates_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tve_pkg::CFG_TAU:    tau_q     <= cfg_data_i[23:0];
          tve_pkg::CFG_DT_MIN: gate_lo_q <= cfg_data_i;
          tve_pkg::CFG_DT_MAX: gate_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_vel_q = {expected_vel_q,
                          track_sample(device_i, pos_x_i, pos_y_i, pos_z_i, stamp_ns_i)};
      if (out_valid_i && out_ready_i) begin
        got = '{vel_x_i, vel_y_i, vel_z_i, updated_i};
        if (expected_vel_q.size() == 0) begin
          err_count_o++;
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result transfer with nothing expected: %p", got);
        end else begin
          want = expected_vel_q.pop_front();
          if (want.upd) updates_o++;
          if (got !== want) begin
            err_count_o++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: velocity mismatch at %0t: expected vx=%0d vy=%0d vz=%0d upd=%0b,",
                       $realtime, want.vx, want.vy, want.vz, want.upd);
              $display("       got vx=%0d vy=%0d vz=%0d upd=%0b",
                       got.vx, got.vy, got.vz, got.upd);
            end
          end
        end
      end
    end
  end
endmodule

FILE: sim/tracker_velocity_estimator_test.sv
`timescale 1ns / 100ps
module tracker_velocity_estimator_test;

  localparam int STALL_LIMIT = 30000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [tve_pkg::CFG_IDX_W-1:0]  cfg_idx_i = tve_pkg::CFG_TAU;
  logic [tve_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [tve_pkg::DEV_W-1:0]      device_i = '0;
  logic signed [31:0]             pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [63:0]                    stamp_ns_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic signed [31:0]             vel_x_o, vel_y_o, vel_z_o;
  logic                           updated_o;
  int                             err_count, pending, updates;

  int                    send_idle_pct = 12;
  int                    recv_idle_pct = 73;
  int                    holdoff_req = 0;
  int                    transfers = 0;
  int                    phases_run = 0;
  logic [63:0]           dev_stamp [tve_pkg::NUM_DEVICES];
  logic signed [31:0]    dev_pos   [tve_pkg::NUM_DEVICES][3];
  logic [31:0]           gate_lo = tve_pkg::DT_MIN_RESET;
  logic [31:0]           gate_hi = tve_pkg::DT_MAX_RESET;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tracker_velocity_estimator i_dut (.*);

  tracker_velocity_estimator_check i_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .device_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .stamp_ns_i, .out_valid_i(out_valid_o), .out_ready_i,
    .vel_x_i(vel_x_o), .vel_y_i(vel_y_o), .vel_z_i(vel_z_o), .updated_i(updated_o),
    .err_count_o(err_count), .pending_o(pending), .updates_o(updates));

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    static int seen_req = 0;
    static int hold_left = 0;
    if (rst_ni) begin
      if (holdoff_req != seen_req) begin
        seen_req  = holdoff_req;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    static int quiet = 0;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
      transfers++;
    end else if (rst_ni) begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(input logic dev, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic signed [31:0] pz,
                             input logic [63:0] stamp);
    int gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    device_i   <= dev;
    pos_x_i    <= px;
    pos_y_i    <= py;
    pos_z_i    <= pz;
    stamp_ns_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    dev_stamp[dev] = stamp;
    dev_pos[dev][0] = px;
    dev_pos[dev][1] = py;
    dev_pos[dev][2] = pz;
  endtask

  // let the block drain, then write registers
  task automatic set_gate(input logic [23:0] tau, input logic [31:0] lo,
                          input logic [31:0] hi);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= tve_pkg::CFG_TAU; cfg_data_i <= {8'd0, tau};
    @(posedge clk_i);
    cfg_idx_i <= tve_pkg::CFG_DT_MIN; cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i <= tve_pkg::CFG_DT_MAX; cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gate_lo = lo;
    gate_hi = hi;
    phases_run++;
  endtask

  function automatic logic signed [31:0] next_pos(input logic signed [31:0] prev);
    if ($urandom_range(99) < 75)
      return prev + $signed($urandom_range(4000)) - 32'sd2000;
    return $urandom;
  endfunction

  // mostly in-gate steps with random walk, some broken timing
  task automatic random_sample();
    logic        dev;
    logic [63:0] span, dt, stamp;
    int          pick;
    dev  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    span = 64'(gate_hi) - 64'(gate_lo);
    if (pick < 80 && span > 1) begin
      dt = 64'(gate_lo) + 1 + (64'($urandom) % (span - 1));
    end else begin
      case ($urandom_range(4))
        0: dt = 64'(gate_lo);
        1: dt = 64'(gate_hi);
        2: dt = -64'($urandom_range(1000, 1));
        3: dt = {$urandom, $urandom};
        default: dt = 64'($urandom_range(100000));
      endcase
    end
    stamp = dev_stamp[dev] + dt;
    send_sample(dev, next_pos(dev_pos[dev][0]), next_pos(dev_pos[dev][1]),
                next_pos(dev_pos[dev][2]), stamp);
  endtask

  initial begin
    static logic [23:0] tau_set [5] = '{24'd0, 24'hffffff, 24'd1, 24'd10000000,
                                       tve_pkg::TAU_RESET};
    static logic [31:0] lo_set  [5] = '{32'd0, 32'd1000, 32'd100, 32'hfffffff0,
                                       tve_pkg::DT_MIN_RESET};
    static logic [31:0] hi_set  [5] = '{32'hffffffff, 32'd200000, 32'd5000000,
                                       32'hffffffff, tve_pkg::DT_MAX_RESET};
    int n;
    for (int d = 0; d < tve_pkg::NUM_DEVICES; d++) begin
      dev_stamp[d] = '0;
      for (int a = 0; a < 3; a++) dev_pos[d][a] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first samples, gate edges, position extremes, backward stamp
    send_sample(1'b0, 32'sd0, 32'sd0, 32'sd0, 64'd1000);
    send_sample(1'b0, 32'sd65536, -32'sd65536, 32'sd1,
                64'd1000 + 64'(tve_pkg::DT_MIN_RESET) + 1);
    send_sample(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 64'hffffffff00000000);
    send_sample(1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                64'hffffffff00000000 + 64'(tve_pkg::DT_MIN_RESET) + 1);
    send_sample(1'b1, 32'sh7fffffff, 32'sh80000000, 32'sd0,
                64'hffffffff00000000 + 2 * 64'(tve_pkg::DT_MIN_RESET) + 2);
    send_sample(1'b0, 32'sd100, 32'sd100, 32'sd100,
                dev_stamp[0] + 64'(tve_pkg::DT_MIN_RESET));
    send_sample(1'b0, 32'sd200, 32'sd0, -32'sd100,
                dev_stamp[0] + 64'(tve_pkg::DT_MAX_RESET));
    send_sample(1'b0, 32'sd300, 32'sd5, -32'sd7,
                dev_stamp[0] + 64'(tve_pkg::DT_MAX_RESET) - 1);
    send_sample(1'b0, 32'sd301, 32'sd6, -32'sd8, dev_stamp[0] - 64'd5);
    send_sample(1'b0, 32'sd999, 32'sd6, -32'sd8, dev_stamp[0] + 64'd20000000);
    send_sample(1'b1, 32'sd0, 32'sd0, 32'sd0, 64'hffffffffffffffff);
    send_sample(1'b1, -32'sd1, 32'sd1, 32'sd0, 64'd30000000 - 64'd1);
    // zero time constant, gate wide open
    set_gate(24'd0, 32'd0, 32'hffffffff);
    send_sample(1'b0, 32'sd5000, 32'sd0, 32'sd0, dev_stamp[0] + 64'd1);
    send_sample(1'b0, 32'sh80000000, 32'sd0, 32'sd0, dev_stamp[0] + 64'd1);
    send_sample(1'b0, 32'sh7fffffff, 32'sd0, 32'sd0, dev_stamp[0] + 64'hfffffffe);
    send_sample(1'b1, 32'sd1, 32'sd1, 32'sd1, dev_stamp[1] + 64'd0);
    send_sample(1'b1, 32'sd2, 32'sd3, 32'sd4, dev_stamp[1] + 64'd1000);

    // random phases over several register settings and idle patterns
    n = 0;
    for (int ph = 0; ph < 5; ph++) begin
      set_gate(tau_set[ph], lo_set[ph], hi_set[ph]);
      for (int k = 0; k < 140; k++) begin
        if (n == 233) begin
          send_idle_pct = 73;
          recv_idle_pct = 12;
        end
        if (n == 466) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == 300 || n == 600) holdoff_req = holdoff_req + 1;
        random_sample();
        n++;
      end
    end
    in_valid_i <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d samples over %0d register settings, %0d velocity updates,",
             n + 17, phases_run, updates);
    $display("gate edges, stamp wrap and position extremes under random stalls and a long hold-off");
    if (err_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/tve_pkg.sv
hdl/tve_div.sv
hdl/tve_dp.sv
hdl/tve_ctrl.sv
hdl/tracker_velocity_estimator.sv
sim/tracker_velocity_estimator_check.sv
sim/tracker_velocity_estimator_test.sv
